@@ sv/qir_pkg.sv @@
// ----------------------------------------------------------------------------
// qir_pkg
// Shared types, constants and helper functions of the quadratic resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package qir_pkg;

  localparam int MAX_CHANNELS   = 8;
  localparam int HISTORY_FRAMES = 3;
  localparam int MAX_RESULTS    = 64;

  localparam int SAMPLE_W = 16;
  localparam int CHAN_W   = $clog2(MAX_CHANNELS);
  localparam int ROW_W    = SAMPLE_W * HISTORY_FRAMES;
  localparam int POS_W    = 24;
  localparam int X_W      = 17;
  localparam int STEP_W   = 20;
  localparam int CCNT_W   = 4;
  localparam int FS_W     = 2;
  localparam int FOUT_W   = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = STEP_W;

  localparam logic [POS_W-1:0]  ONE_Q16    = 24'h01_0000;
  localparam logic [POS_W-1:0]  TWO_Q16    = 24'h02_0000;
  localparam logic [STEP_W-1:0] MIN_STEP   = 20'd8192;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
  localparam logic [CCNT_W-1:0] CCNT_RESET = 4'd2;
  localparam logic [FS_W-1:0]   FS_FULL    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STEP          = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_CHECK,
    S_READ,
    S_CALC,
    S_WAIT
  } qir_state_t;

  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] row;
    logic [X_W-1:0]   x;
  } qir_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] y;
  } qir_rsp_t;

  function automatic logic [CCNT_W-1:0] eff_channels(input logic [CCNT_W-1:0] c);
    logic [CCNT_W-1:0] r;
    r = c;
    if (c == '0) r = CCNT_W'(1);
    else if (c > CCNT_W'(MAX_CHANNELS)) r = CCNT_W'(MAX_CHANNELS);
    return r;
  endfunction

  function automatic logic [FOUT_W-1:0] frame_cap(input logic [CCNT_W-1:0] ch);
    logic [FOUT_W-1:0] r;
    case (ch)
      4'd1:    r = FOUT_W'(MAX_RESULTS / 1);
      4'd2:    r = FOUT_W'(MAX_RESULTS / 2);
      4'd3:    r = FOUT_W'(MAX_RESULTS / 3);
      4'd4:    r = FOUT_W'(MAX_RESULTS / 4);
      4'd5:    r = FOUT_W'(MAX_RESULTS / 5);
      4'd6:    r = FOUT_W'(MAX_RESULTS / 6);
      4'd7:    r = FOUT_W'(MAX_RESULTS / 7);
      default: r = FOUT_W'(MAX_RESULTS / 8);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/qir_ram.sv @@
// ----------------------------------------------------------------------------
// qir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qir_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/qir_interp.sv @@
// ----------------------------------------------------------------------------
// qir_interp
// Five-stage pipeline evaluating the three-point quadratic at a Q16 offset,
// with round-half-up and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module qir_interp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qir_pkg::qir_req_t req,
  output qir_pkg::qir_rsp_t      rsp
);

  import qir_pkg::*;

  localparam int N_W = 56;
  localparam logic signed [N_W-1:0] ROUND_HALF = 56'sd1 <<< 32;

  logic [4:0] v_r;

  logic signed [SAMPLE_W-1:0] h0_c, h1_c, h2_c;
  logic signed [18:0]         a_c;
  logic signed [19:0]         b_c;

  logic signed [18:0]         a1_r;
  logic signed [19:0]         b1_r;
  logic signed [SAMPLE_W-1:0] h0_1_r, h0_2_r, h0_3_r;
  logic        [X_W-1:0]      x1_r, x2_r;

  logic signed [36:0] ax2_r;
  logic signed [37:0] bx2_r, bx3_r;

  logic signed [18:0] ax_hi;
  logic signed [18:0] ax_lo;
  logic signed [36:0] p_hi3_r, p_lo3_r;

  logic signed [N_W-1:0] n_c, n4_r;
  logic signed [22:0]    r_c;
  logic signed [SAMPLE_W-1:0] y_c, y_r;

  assign h0_c = req.row[SAMPLE_W-1:0];
  assign h1_c = req.row[2*SAMPLE_W-1:SAMPLE_W];
  assign h2_c = req.row[3*SAMPLE_W-1:2*SAMPLE_W];

  always_comb begin
    a_c = 19'(h0_c) - (19'(h1_c) <<< 1) + 19'(h2_c);
    b_c = (20'(h1_c) <<< 2) - (20'(h0_c) <<< 1) - 20'(h0_c) - 20'(h2_c);
  end

  assign ax_hi = ax2_r[36:18];
  assign ax_lo = $signed({1'b0, ax2_r[17:0]});

  always_comb begin
    n_c = (N_W'(p_hi3_r) <<< 18) + N_W'(p_lo3_r) + (N_W'(bx3_r) <<< 16)
        + (N_W'(h0_3_r) <<< 33) + ROUND_HALF;
  end

  always_comb begin
    r_c = n4_r[N_W-1:33];
    if (r_c > 23'sd32767) begin
      y_c = 16'sh7FFF;
    end else if (r_c < -23'sd32768) begin
      y_c = -16'sh8000;
    end else begin
      y_c = r_c[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    a1_r    <= a_c;
    b1_r    <= b_c;
    h0_1_r  <= h0_c;
    x1_r    <= req.x;
    ax2_r   <= a1_r * $signed({1'b0, x1_r});
    bx2_r   <= b1_r * $signed({1'b0, x1_r});
    h0_2_r  <= h0_1_r;
    x2_r    <= x1_r;
    p_hi3_r <= ax_hi * $signed({1'b0, x2_r});
    p_lo3_r <= ax_lo * $signed({1'b0, x2_r});
    bx3_r   <= bx2_r;
    h0_3_r  <= h0_2_r;
    n4_r    <= n_c;
    y_r     <= y_c;
  end

  assign rsp.done = v_r[4];
  assign rsp.y    = y_r;

endmodule

`default_nettype wire

@@ sv/quadratic_interp_resampler.sv @@
// ----------------------------------------------------------------------------
// quadratic_interp_resampler
// Interleaved multichannel resampler with quadratic interpolation over the
// last three frames, kept per channel in a small history RAM.
// Flow: each accepted item is written to the history in an update state, with
// the input held off; once three frames are held, a completed frame adds a
// check state, and each result then passes through a read and the five-stage
// interpolation pipeline into the output register. A result waits for the
// receiver to drain the output register, and no new input is taken until the
// check state finds no further result to emit.
// Reset: synchronous; history reads as zero through per-channel valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_interp_resampler (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [qir_pkg::SAMPLE_W-1:0]    in_input_sample,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [qir_pkg::SAMPLE_W-1:0]         out_output_sample,
  output logic        [qir_pkg::CHAN_W-1:0]           out_channel,
  output logic                                        out_last_of_run,
  input  wire logic                                   cfg_we,
  input  wire logic   [qir_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic   [qir_pkg::CFG_W-1:0]            cfg_wdata
);

  import qir_pkg::*;

  qir_state_t state_r, state_nxt;

  logic [STEP_W-1:0] step_r;
  logic [CCNT_W-1:0] chan_cnt_r;
  logic [POS_W-1:0]  pos_r;
  logic [CHAN_W-1:0] cc_r;
  logic [FS_W-1:0]   fs_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [CHAN_W-1:0] ch_idx_r;
  logic [FOUT_W-1:0] frames_out_r;
  logic [MAX_CHANNELS-1:0] hist_valid_r;
  logic [CHAN_W-1:0] rd_addr_r;

  logic                    out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [CHAN_W-1:0]       out_channel_r;
  logic                    out_last_r;

  logic              ram_we;
  logic [CHAN_W-1:0] ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  row_eff;
  logic [ROW_W-1:0]  new_row;

  logic [CCNT_W-1:0] ch_eff;
  logic [FOUT_W-1:0] cap;
  logic [STEP_W-1:0] st_eff;
  logic              in_take;
  logic              frame_done;
  logic              fs_full;
  logic [POS_W-1:0]  pos_dec;
  logic [POS_W-1:0]  pos_sum;
  logic              emit_ok;
  logic              chan_last;
  logic              run_last;
  logic              load_out;

  qir_req_t req;
  qir_rsp_t rsp;

  assign ch_eff  = eff_channels(chan_cnt_r);
  assign cap     = frame_cap(ch_eff);
  assign st_eff  = (step_r < MIN_STEP) ? MIN_STEP : step_r;
  assign in_take = in_valid && in_ready;
  assign row_eff = hist_valid_r[rd_addr_r] ? ram_rdata : '0;

  assign frame_done = ({1'b0, cc_r} + CCNT_W'(1)) >= ch_eff;
  assign fs_full    = (fs_r == FS_FULL);
  assign pos_dec    = (pos_r >= ONE_Q16) ? (pos_r - ONE_Q16) : '0;
  assign pos_sum    = pos_r + POS_W'(st_eff);
  assign emit_ok    = (pos_r < TWO_Q16) && (frames_out_r < cap);
  assign chan_last  = ({1'b0, ch_idx_r} + CCNT_W'(1)) == ch_eff;
  assign run_last   = chan_last
                   && ((pos_sum >= TWO_Q16) || ((frames_out_r + FOUT_W'(1)) >= cap));
  assign load_out   = (state_r == S_WAIT) && rsp.done;

  always_comb begin
    case (fs_r)
      2'd0:    new_row = {row_eff[3*SAMPLE_W-1:SAMPLE_W], sample_r};
      2'd1:    new_row = {row_eff[3*SAMPLE_W-1:2*SAMPLE_W], sample_r,
                          row_eff[SAMPLE_W-1:0]};
      2'd2:    new_row = {sample_r, row_eff[2*SAMPLE_W-1:0]};
      default: new_row = {sample_r, row_eff[3*SAMPLE_W-1:SAMPLE_W]};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (frame_done && (fs_full || fs_r == (FS_FULL - FS_W'(1)))) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CHECK: begin
        state_nxt = emit_ok ? S_READ : S_IDLE;
      end
      S_READ: begin
        if (!out_valid_r) state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) state_nxt = chan_last ? S_CHECK : S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    ram_raddr = (state_r == S_IDLE) ? cc_r : ch_idx_r;
    ram_we    = (state_r == S_UPDATE);
    req.start = (state_r == S_CALC);
    req.row   = row_eff;
    req.x     = pos_r[X_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_RESET;
      chan_cnt_r <= CCNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP:          step_r     <= cfg_wdata[STEP_W-1:0];
        REG_CHANNEL_COUNT: chan_cnt_r <= cfg_wdata[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      cc_r         <= '0;
      fs_r         <= '0;
      ch_idx_r     <= '0;
      frames_out_r <= '0;
      hist_valid_r <= '0;
    end else begin
      if (state_r == S_UPDATE) begin
        hist_valid_r[rd_addr_r] <= 1'b1;
        if (frame_done) begin
          cc_r         <= '0;
          ch_idx_r     <= '0;
          frames_out_r <= '0;
          if (fs_full) begin
            pos_r <= pos_dec;
          end else begin
            fs_r <= fs_r + FS_W'(1);
          end
        end else begin
          cc_r <= cc_r + CHAN_W'(1);
        end
      end
      if (load_out) begin
        if (chan_last) begin
          ch_idx_r     <= '0;
          pos_r        <= pos_sum;
          frames_out_r <= frames_out_r + FOUT_W'(1);
        end else begin
          ch_idx_r <= ch_idx_r + CHAN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= ram_raddr;
    if (in_take) begin
      sample_r <= in_input_sample;
    end
    if (load_out) begin
      out_sample_r  <= rsp.y;
      out_channel_r <= ch_idx_r;
      out_last_r    <= run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  qir_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_r),
    .wdata (new_row),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qir_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign out_valid         = out_valid_r;
  assign out_output_sample = out_sample_r;
  assign out_channel       = out_channel_r;
  assign out_last_of_run   = out_last_r;

endmodule

`default_nettype wire
